[rtl/kdlpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// kdlpr_pkg: shared types and constants of the key debounce block
// Request and response payloads, configuration image, event codes and
// per-key phase encoding.
// -----------------------------------------------------------------------------
package kdlpr_pkg;

   localparam int KEY_W       = 3;
   localparam int TICK_W      = 16;
   localparam int MASK_W      = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Reset values of the duration and polarity registers.
   localparam logic [TICK_W-1:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [TICK_W-1:0] LONG_PRESS_RESET = 16'd800;
   localparam logic [TICK_W-1:0] REPEAT_RESET     = 16'd150;
   localparam logic [MASK_W-1:0] MASK_RESET       = 8'h01;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT      = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_MASK = 4'd3;

   typedef enum logic [2:0] {
      EV_NONE         = 3'd0,
      EV_PRESS        = 3'd1,
      EV_RELEASE      = 3'd2,
      EV_LONG         = 3'd3,
      EV_REPEAT       = 3'd4,
      EV_LONG_RELEASE = 3'd5
   } event_type;

   typedef enum logic [3:0] {
      PH_WAIT     = 4'b0001,
      PH_DEBOUNCE = 4'b0010,
      PH_HELD     = 4'b0100,
      PH_LONG     = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_index;
      logic             raw_level;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_number;
      logic [2:0]       event_code;
      logic [2:0]       held_status;
      logic             pressed_level;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] debounce_ticks;
      logic [TICK_W-1:0] long_press_ticks;
      logic [TICK_W-1:0] repeat_ticks;
      logic [MASK_W-1:0] active_high_mask;
   } cfg_type;

endpackage
`default_nettype wire

[rtl/kdlpr_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// kdlpr_csr: configuration registers
// Holds the three duration registers and the polarity mask; writes to an
// index beyond the register list are dropped.
// -----------------------------------------------------------------------------
module kdlpr_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [kdlpr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [kdlpr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output      kdlpr_pkg::cfg_type                   cfg
);
   import kdlpr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_index)
            CSR_DEBOUNCE:    cfg_in.debounce_ticks   = csr_wdata[TICK_W-1:0];
            CSR_LONG_PRESS:  cfg_in.long_press_ticks = csr_wdata[TICK_W-1:0];
            CSR_REPEAT:      cfg_in.repeat_ticks     = csr_wdata[TICK_W-1:0];
            CSR_ACTIVE_MASK: cfg_in.active_high_mask = csr_wdata[MASK_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= LONG_PRESS_RESET;
         cfg_ff.repeat_ticks     <= REPEAT_RESET;
         cfg_ff.active_high_mask <= MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[rtl/kdlpr_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// kdlpr_step: per-key phase update
// Next phase, countdown and last event of one key for one pressed sample.
// -----------------------------------------------------------------------------
module kdlpr_step #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire kdlpr_pkg::phase_type      phase,
   input  wire logic [COUNT_WIDTH-1:0]    count,
   input  wire kdlpr_pkg::event_type      last_event,
   input  wire logic                      pressed,
   input  wire kdlpr_pkg::cfg_type        cfg,
   output      kdlpr_pkg::phase_type      phase_next,
   output      logic [COUNT_WIDTH-1:0]    count_next,
   output      kdlpr_pkg::event_type      last_next,
   output      kdlpr_pkg::event_type      event_now
);
   import kdlpr_pkg::*;

   localparam int LOAD_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
   localparam logic [LOAD_W-1:0] COUNT_MAX = LOAD_W'({COUNT_WIDTH{1'b1}});

   logic [COUNT_WIDTH-1:0] load_debounce;
   logic [COUNT_WIDTH-1:0] load_long;
   logic [COUNT_WIDTH-1:0] load_repeat;
   logic                   expired;
   logic [COUNT_WIDTH-1:0] count_dec;

   // Durations wider than the counter saturate at its maximum.
   function automatic logic [COUNT_WIDTH-1:0] sat_load(input logic [TICK_W-1:0] ticks);
      logic [LOAD_W-1:0] wide;
      wide = LOAD_W'(ticks);
      if (wide > COUNT_MAX) begin
         wide = COUNT_MAX;
      end
      return wide[COUNT_WIDTH-1:0];
   endfunction

   assign load_debounce = sat_load(cfg.debounce_ticks);
   assign load_long     = sat_load(cfg.long_press_ticks);
   assign load_repeat   = sat_load(cfg.repeat_ticks);

   // A countdown of one or zero expires on this tick.
   assign expired   = (count <= COUNT_WIDTH'(1));
   assign count_dec = count - COUNT_WIDTH'(1);

   always_comb begin
      phase_next = phase;
      count_next = count;
      event_now  = EV_NONE;
      case (phase)
         PH_WAIT: begin
            if (pressed) begin
               phase_next = PH_DEBOUNCE;
               count_next = load_debounce;
            end
         end
         PH_DEBOUNCE: begin
            if (!pressed) begin
               phase_next = PH_WAIT;
               count_next = load_debounce;
            end else if (expired) begin
               event_now  = EV_PRESS;
               phase_next = PH_HELD;
               count_next = load_long;
            end else begin
               count_next = count_dec;
            end
         end
         PH_HELD: begin
            if (!pressed) begin
               event_now  = EV_RELEASE;
               phase_next = PH_WAIT;
               count_next = load_debounce;
            end else if (expired) begin
               event_now  = EV_LONG;
               phase_next = PH_LONG;
               count_next = load_repeat;
            end else begin
               count_next = count_dec;
            end
         end
         PH_LONG: begin
            if (!pressed) begin
               event_now  = EV_LONG_RELEASE;
               phase_next = PH_WAIT;
               count_next = load_debounce;
            end else if (expired) begin
               event_now  = EV_REPEAT;
               count_next = load_repeat;
            end else begin
               count_next = count_dec;
            end
         end
         default: begin
            phase_next = PH_WAIT;
            count_next = load_debounce;
         end
      endcase
   end

   assign last_next = (event_now != EV_NONE) ? event_now : last_event;

endmodule
`default_nettype wire

[rtl/key_debounce_long_press_repeat.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// key_debounce_long_press_repeat: debounced keys with long press and repeat
// Scan ticks for up to eight keys come in one at a time; each tick yields
// one response with the event, the last recorded event and the level.
// -----------------------------------------------------------------------------
//
//   Channel   Ports                            Direction  Moves
//   request   req_valid req_stall req_data     in         one scan tick
//   response  rsp_valid rsp_stall rsp_data     out        one event record
//   config    csr_valid csr_ready csr_index    in         one register write
//             csr_wdata
//
// One request is taken every cycle unless req_stall is high. A request
// passes the request register, which feeds the per-key read-modify-write,
// and the response register, which holds the result. The key state is
// written in the same edge that loads the response, so back-to-back ticks
// for one key see each other's updates. Reset is synchronous and puts
// every key in the wait phase with the reset debounce count; configuration
// is usable at once. A stalled response holds the response register and a
// full request register, and req_stall rises only while both are full.
//
module key_debounce_long_press_repeat #(
   parameter int NUM_KEYS    = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire kdlpr_pkg::req_type                  req_data,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      kdlpr_pkg::rsp_type                  rsp_data,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [kdlpr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [kdlpr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import kdlpr_pkg::*;

   // Only eight keys can be addressed by the request, so no more state is kept.
   localparam int KEYS      = (NUM_KEYS < (1 << KEY_W)) ? NUM_KEYS : (1 << KEY_W);
   localparam int KEY_IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;

   cfg_type cfg;

   // Request register.
   logic    in_valid_ff;
   req_type in_data_ff;

   // Response register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_in;

   // Per-key state.
   phase_type              phase_ff [KEYS];
   logic [COUNT_WIDTH-1:0] count_ff [KEYS];
   event_type              last_ff  [KEYS];

   logic                   out_free;
   logic                   advance;
   logic                   in_range;
   logic [KEY_IDX_W-1:0]   key_idx;
   logic                   pressed;
   phase_type              phase_in;
   logic [COUNT_WIDTH-1:0] count_in;
   event_type              last_in;
   event_type              event_now;

   kdlpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The response register can take a new result when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Keys beyond the configured count leave all state alone and report zeros apart from the key number.
   assign in_range = ({1'b0, in_data_ff.key_index} < (KEY_W + 1)'(KEYS));
   assign key_idx  = in_range ? in_data_ff.key_index[KEY_IDX_W-1:0] : '0;

   // The polarity bit turns the raw pin level into an active-high press.
   assign pressed = in_data_ff.raw_level == cfg.active_high_mask[in_data_ff.key_index];

   kdlpr_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .phase      (phase_ff[key_idx]),
      .count      (count_ff[key_idx]),
      .last_event (last_ff[key_idx]),
      .pressed    (pressed),
      .cfg        (cfg),
      .phase_next (phase_in),
      .count_next (count_in),
      .last_next  (last_in),
      .event_now  (event_now)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYS; k++) begin
            phase_ff[k] <= PH_WAIT;
            count_ff[k] <= COUNT_WIDTH'(DEBOUNCE_RESET);
            last_ff[k]  <= EV_NONE;
         end
      end else if (advance && in_range) begin
         phase_ff[key_idx] <= phase_in;
         count_ff[key_idx] <= count_in;
         last_ff[key_idx]  <= last_in;
      end
   end

   always_comb begin
      rsp_in.key_number    = in_data_ff.key_index;
      rsp_in.event_code    = EV_NONE;
      rsp_in.held_status   = EV_NONE;
      rsp_in.pressed_level = 1'b0;
      if (in_range) begin
         rsp_in.event_code    = event_now;
         rsp_in.held_status   = last_in;
         rsp_in.pressed_level = pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[rtl/kdlpr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// kdlpr_checker: port-level checks of the key debounce block
// Watches the request and response ports over time.
// -----------------------------------------------------------------------------
module kdlpr_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire kdlpr_pkg::req_type                  req_data,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire kdlpr_pkg::rsp_type                  rsp_data
);
   import kdlpr_pkg::*;

   logic press_like;
   logic release_like;

   assign press_like   = rsp_data.event_code == EV_PRESS || rsp_data.event_code == EV_LONG
                         || rsp_data.event_code == EV_REPEAT;
   assign release_like = rsp_data.event_code == EV_RELEASE
                         || rsp_data.event_code == EV_LONG_RELEASE;

   // A stalled request keeps its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   // A stalled response keeps its content.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Requests are only held off while a finished response waits.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free response register");

   // Any event is also the recorded last event of that key.
   a_event_recorded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_code != EV_NONE |-> rsp_data.held_status == rsp_data.event_code)
      else $error("event not recorded as held status");

   // Press-type events need a pressed key, release-type events a released one.
   a_event_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!press_like || rsp_data.pressed_level)
                    && (!release_like || !rsp_data.pressed_level))
      else $error("event disagrees with pressed level");

endmodule

bind key_debounce_long_press_repeat kdlpr_checker u_kdlpr_checker (.*);
`default_nettype wire
